// ===== rtl/josephus_elimination_order_defines.svh =====
`ifndef JOSEPHUS_ELIMINATION_ORDER_DEFINES_SVH
`define JOSEPHUS_ELIMINATION_ORDER_DEFINES_SVH

// same-cycle implication, clocked on clock, quiet in reset
`define JEO_CHECK_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define JEO_CHECK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/jeo_pkg.sv =====
package jeo_pkg;

   localparam int NPEOPLE_W = 11;
   localparam int STEP_W    = 16;
   localparam int CSR_IDX_W = 2;
   localparam int OUT_W     = 10;
   localparam int STEP_CNT_W = $clog2(STEP_W);

   localparam logic [CSR_IDX_W-1:0] CSR_N_PEOPLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP     = 2'd1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CLEAR,
      S_MOD,
      S_FIX,
      S_RD,
      S_CALC,
      S_LEAF
   } state_type;

   typedef struct packed {
      logic start_round;
      logic clr_step;
      logic mod_init;
      logic mod_step;
      logic desc_init;
      logic desc_rd;
      logic desc_calc;
      logic leaf_wr;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic sweep_done;
      logic mod_done;
      logic at_leaf;
      logic rsp_busy;
   } status_type;

endpackage

// ===== rtl/josephus_elimination_order.sv =====
// Josephus elimination order generator.
// Input channel req_*: one request per elimination; req_tdata[0] is restart.
// Output channel rsp_*: one result per request, carrying the eliminated
// index and its position in the round; rsp_tlast marks the survivor.
// csr_*: n_people (index 0) and step_count (index 1), to be written only
// while idle; the block itself does not enforce this. A request with restart
// set, or the first one after a round finished, latches n_people and clears
// the node count memory, one entry per cycle, all 2 * 2^ceil(log2(MAX_PEOPLE))
// entries (2048 for the default). Each elimination then computes step_count
// mod remaining in a bit-serial remainder unit, forms the target, and walks
// the tree level by level (memory read, then compare and update). The memory's
// single read port sets the descent rate.
// Reset empties the circle and loads n_people = 1024, step_count = 2.
// One request is worked at a time; a result waits in the output register
// while the receiver stalls, and the next request is taken meanwhile but
// its result is held back until that register frees up.
module josephus_elimination_order #(
   parameter int MAX_PEOPLE = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] restart, [7:1] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [9:0] eliminated_index, [19:10] order_position
   output logic        rsp_tlast,   // last_of_round
   input  logic        csr_we,
   input  logic [jeo_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [jeo_pkg::STEP_W-1:0]    csr_wdata
);
   import jeo_pkg::*;

   cmd_type          cmd;
   status_type       status;
   logic [OUT_W-1:0] rsp_index, rsp_position;

   jeo_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_restart (req_tdata[0]),
      .req_tready  (req_tready),
      .status      (status),
      .cmd         (cmd)
   );

   jeo_dp #(.MAX_PEOPLE(MAX_PEOPLE)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .status       (status),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_index    (rsp_index),
      .rsp_position (rsp_position),
      .rsp_last     (rsp_tlast)
   );

   assign rsp_tdata = {4'b0, rsp_position, rsp_index};

endmodule

// ===== rtl/jeo_ctrl.sv =====
module jeo_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_restart,
   output logic                req_tready,
   input  jeo_pkg::status_type status,
   output jeo_pkg::cmd_type    cmd
);
   import jeo_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_restart || status.empty) begin
                  cmd.start_round = 1'b1;
                  state_in = S_CLEAR;
               end else begin
                  cmd.mod_init = 1'b1;
                  state_in = S_MOD;
               end
            end
         end
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.sweep_done) begin
               cmd.mod_init = 1'b1;
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            cmd.mod_step = 1'b1;
            if (status.mod_done) state_in = S_FIX;
         end
         S_FIX: begin
            cmd.desc_init = 1'b1;
            state_in = S_RD;
         end
         S_RD: begin
            if (status.at_leaf) begin
               state_in = S_LEAF;
            end else begin
               cmd.desc_rd = 1'b1;
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            cmd.desc_calc = 1'b1;
            state_in = S_RD;
         end
         S_LEAF: begin
            // wait for the output register to free up
            if (!status.rsp_busy) begin
               cmd.leaf_wr = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// ===== rtl/jeo_dp.sv =====
`include "josephus_elimination_order_defines.svh"

module jeo_dp #(
   parameter int MAX_PEOPLE = 1024
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [jeo_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [jeo_pkg::STEP_W-1:0]             csr_wdata,
   input  jeo_pkg::cmd_type                       cmd,
   output jeo_pkg::status_type                    status,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [jeo_pkg::OUT_W-1:0]              rsp_index,
   output logic [jeo_pkg::OUT_W-1:0]              rsp_position,
   output logic                                   rsp_last
);
   import jeo_pkg::*;

   localparam int LEVELS = (MAX_PEOPLE > 1) ? $clog2(MAX_PEOPLE) : 1;
   localparam int NW     = LEVELS + 1;
   localparam int DEPTH  = 1 << NW;
   localparam logic [NW-1:0] LEAF_BASE = NW'(1 << LEVELS);
   localparam logic [NW-1:0] MAX_N     = NW'(MAX_PEOPLE);

   logic [NPEOPLE_W-1:0]  n_people_ff;
   logic [STEP_W-1:0]     step_ff;
   logic [NW-1:0]         n_round_ff, elim_ff, pos_ff, sweep_ff;
   logic [NW-1:0]         rem_ff, t_ff, p_ff, lo_ff, size_ff, cur_ff, rd_ff;
   logic [STEP_W-1:0]     dvd_ff;
   logic [STEP_CNT_W-1:0] cnt_ff;
   logic                  rsp_valid_ff, rsp_last_ff;
   logic [OUT_W-1:0]      rsp_index_ff, rsp_position_ff;

   // removed-count per tree node; alive = full span count minus removed
   logic [NW-1:0]         mem [DEPTH];

   logic [NW-1:0]   remaining, n_clamp, pos_wrap, t_fix, half, full_l, alive_l;
   logic [NW:0]     r_shift, rem_in;
   logic [NW+1:0]   sum, r1, r2;
   logic            mem_we;
   logic [NW-1:0]   mem_wa, mem_wd;

   assign remaining = n_round_ff - elim_ff;

   always_comb begin
      if (n_people_ff == '0) begin
         n_clamp = NW'(1);
      end else if (32'(n_people_ff) > 32'(MAX_PEOPLE)) begin
         n_clamp = MAX_N;
      end else begin
         n_clamp = NW'(n_people_ff);
      end
   end

   // restoring remainder, one step bit per cycle
   assign r_shift = {rem_ff, dvd_ff[STEP_W-1]};
   assign rem_in  = (r_shift >= {1'b0, remaining}) ? r_shift - {1'b0, remaining} : r_shift;

   assign pos_wrap = (pos_ff == remaining) ? '0 : pos_ff;
   assign r1  = (NW+2)'(remaining);
   assign r2  = r1 << 1;
   assign sum = (NW+2)'(pos_wrap) + (NW+2)'(rem_ff) + r1 - (NW+2)'(1);
   always_comb begin
      priority if (sum >= r2) t_fix = NW'(sum - r2);
      else if (sum >= r1)     t_fix = NW'(sum - r1);
      else                    t_fix = NW'(sum);
   end

   assign half = size_ff >> 1;
   always_comb begin
      if (n_round_ff > lo_ff) begin
         full_l = ((n_round_ff - lo_ff) < half) ? (n_round_ff - lo_ff) : half;
      end else begin
         full_l = '0;
      end
      alive_l = full_l - rd_ff;
   end

   assign mem_we = cmd.clr_step | cmd.desc_calc | cmd.leaf_wr;
   assign mem_wa = cmd.clr_step ? sweep_ff : p_ff;
   assign mem_wd = cmd.clr_step ? '0 : cur_ff + NW'(1);

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (cmd.desc_rd) rd_ff <= mem[{p_ff[NW-2:0], 1'b0}];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_people_ff  <= NPEOPLE_W'(1024);
         step_ff      <= STEP_W'(2);
         n_round_ff   <= '0;
         elim_ff      <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we && csr_index == CSR_N_PEOPLE) n_people_ff <= csr_wdata[NPEOPLE_W-1:0];
         if (csr_we && csr_index == CSR_STEP)     step_ff     <= csr_wdata;
         if (cmd.start_round) begin
            n_round_ff <= n_clamp;
            elim_ff    <= '0;
            pos_ff     <= '0;
         end
         if (cmd.desc_init) pos_ff <= t_fix;
         if (cmd.leaf_wr) begin
            elim_ff      <= elim_ff + NW'(1);
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_round) sweep_ff <= '0;
      else if (cmd.clr_step) sweep_ff <= sweep_ff + NW'(1);
      if (cmd.mod_init) begin
         rem_ff <= '0;
         dvd_ff <= step_ff;
         cnt_ff <= '0;
      end else if (cmd.mod_step) begin
         rem_ff <= rem_in[NW-1:0];
         dvd_ff <= dvd_ff << 1;
         cnt_ff <= cnt_ff + STEP_CNT_W'(1);
      end
      if (cmd.desc_init) begin
         t_ff    <= t_fix;
         p_ff    <= NW'(1);
         lo_ff   <= '0;
         size_ff <= LEAF_BASE;
         cur_ff  <= elim_ff;
      end else if (cmd.desc_calc) begin
         size_ff <= half;
         if (t_ff < alive_l) begin
            p_ff   <= {p_ff[NW-2:0], 1'b0};
            cur_ff <= rd_ff;
         end else begin
            t_ff   <= t_ff - alive_l;
            p_ff   <= {p_ff[NW-2:0], 1'b1};
            lo_ff  <= lo_ff + half;
            cur_ff <= cur_ff - rd_ff;
         end
      end
      if (cmd.leaf_wr) begin
         rsp_index_ff    <= OUT_W'(p_ff[LEVELS-1:0]);
         rsp_position_ff <= OUT_W'(elim_ff);
         rsp_last_ff     <= (remaining == NW'(1));
      end
   end

   assign status.empty      = (elim_ff == n_round_ff);
   assign status.sweep_done = &sweep_ff;
   assign status.mod_done   = &cnt_ff;
   assign status.at_leaf    = p_ff[NW-1];
   assign status.rsp_busy   = rsp_valid_ff & ~rsp_tready;

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_index    = rsp_index_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_last     = rsp_last_ff;

   `JEO_CHECK_NOW(a_leaf_wr_at_leaf, cmd.leaf_wr, p_ff[NW-1], "leaf write above leaf level")
   `JEO_CHECK_NOW(a_rd_not_leaf, cmd.desc_rd, !p_ff[NW-1], "child read from a leaf")
   `JEO_CHECK_NOW(a_t_in_range, cmd.desc_init, t_fix < remaining, "target beyond remaining")
   `JEO_CHECK_NEXT(a_rsp_after_leaf, cmd.leaf_wr, rsp_valid_ff, "result not presented")

endmodule
